@@ sv/steering_servo_angle_interpolator_assert.svh @@
// Assertion macros for the steering servo angle interpolator checks.
`ifndef STEERING_SERVO_ANGLE_INTERPOLATOR_ASSERT_SVH
`define STEERING_SERVO_ANGLE_INTERPOLATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSAI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSAI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ssai_pkg.sv @@
// Shared types and constants of the steering servo angle interpolator.
package ssai_pkg;

    localparam int DATA_W    = 24;   // table points, wheel angles, home offsets
    localparam int IDX_W     = 6;    // point_index port
    localparam int LEN_W     = 7;    // table_length register
    localparam int CFG_IDX_W = 2;
    localparam int OUT_W     = 26;
    localparam int WORD_W    = 2 * DATA_W;
    localparam int MUL_W     = DATA_W + 2;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int MAG_W     = 2 * DATA_W;

    localparam int SSAI_TABLE_DEPTH = 64;
    localparam int SSAI_FRAC_BITS   = 12;

    localparam logic signed [DATA_W-1:0] HOME_RESET = 24'sd368640;
    // 180/pi in Q16, rounded
    localparam logic signed [MUL_W-1:0] DEG_PER_RAD_Q16 = 26'sd3754936;
    localparam logic signed [OUT_W-1:0] OUT_MAX = 26'sd33554431;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -26'sd33554432;

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_CONV = 1'b1
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TABLE_LENGTH = 2'd0,
        REG_HOME_LEFT    = 2'd1,
        REG_HOME_RIGHT   = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_DIVS,
        ST_DIVW,
        ST_SUM,
        ST_NEXT,
        ST_CMUL,
        ST_CABS,
        ST_CSAT,
        ST_DONE
    } ssai_state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } tmem_ctl_t;

endpackage

@@ sv/ssai_tmem.sv @@
// Point table memory: one write port, one registered read port.
module ssai_tmem import ssai_pkg::*; #(
    parameter int TABLE_DEPTH = SSAI_TABLE_DEPTH
) (
    input  logic                           aclk,
    input  tmem_ctl_t                      ctl,
    input  logic [$clog2(TABLE_DEPTH)-1:0] waddr,
    input  logic [WORD_W-1:0]              wdata,
    input  logic [$clog2(TABLE_DEPTH)-1:0] raddr,
    output logic [WORD_W-1:0]              rdata
);

    logic [WORD_W-1:0] mem_q [TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem_q[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rdata <= mem_q[raddr];
        end
    end

endmodule

@@ sv/ssai_div.sv @@
// Restoring divider, one quotient bit per cycle, for the interpolation step.
module ssai_div import ssai_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [MAG_W-1:0]  num,    // must be below den * 2**DATA_W
    input  logic [DATA_W-1:0] den,
    output logic              done,
    output logic [DATA_W-1:0] quo
);

    localparam int CNT_W = $clog2(DATA_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] low_reg;
    logic [DATA_W-1:0] den_reg;
    logic [DATA_W:0]   trial;
    logic              ge;

    assign trial = {rem_reg, low_reg[DATA_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DATA_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // low_reg shifts dividend bits out and quotient bits in
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num[MAG_W-1:DATA_W];
            low_reg <= num[DATA_W-1:0];
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= ge ? DATA_W'(trial - {1'b0, den_reg}) : trial[DATA_W-1:0];
            low_reg <= {low_reg[DATA_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = low_reg;

endmodule

@@ sv/steering_servo_angle_interpolator.sv @@
// Steering servo angle interpolator: table lookup, interpolation and degree conversion.
//
// Input channel (s_valid/s_ready): a load item (s_func = 0) writes one point into
// the table slot s_point_index in the cycle it is accepted and gives no result; the
// next item can follow in the next cycle. A convert item (s_func = 1) looks up the
// negated left and the right wheel angle and gives one result item on the m_ channel.
// Configuration (cfg_valid/cfg_ready, cfg_ready always high) sets table_length and
// the two home offsets; write it only while no convert item is in flight.
// A convert item: each wheel scans the table one slot per cycle from the point
// table memory (one write port, one registered read port), then, when it lands
// between two points, runs one multiply and a serial divide; the degree
// conversion then runs a multiply, a magnitude and a saturate step per wheel.
// An empty table skips the scan. One convert item is worked on at a time.
// The result sits in an output register: the next item is accepted while it waits,
// and a finished result that finds the register still full waits until m_ready.
// Reset clears control state and the registers (table length 0, homes 368640);
// table contents are undefined until loaded.
module steering_servo_angle_interpolator import ssai_pkg::*; #(
    parameter int TABLE_DEPTH = SSAI_TABLE_DEPTH,
    parameter int FRAC_BITS   = SSAI_FRAC_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_func,
    input  logic [IDX_W-1:0]         s_point_index,
    input  logic signed [DATA_W-1:0] s_point_in,
    input  logic signed [DATA_W-1:0] s_point_out,
    input  logic signed [DATA_W-1:0] s_left_wheel,
    input  logic signed [DATA_W-1:0] s_right_wheel,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [OUT_W-1:0]  m_left_servo_deg,
    output logic signed [OUT_W-1:0]  m_right_servo_deg,
    output logic                     m_empty_table
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SH = FRAC_BITS + 8;
    localparam logic [MAG_W-1:0] RND_HALF = MAG_W'(1) << (SH - 1);
    localparam logic [MAG_W-1:0] POS_LIM  = MAG_W'(33554431);
    localparam logic [MAG_W-1:0] NEG_LIM  = MAG_W'(33554432);

    // configuration
    logic [LEN_W-1:0]         table_length_reg;
    logic signed [DATA_W-1:0] home_left_reg;
    logic signed [DATA_W-1:0] home_right_reg;

    // control
    ssai_state_t state_reg, state_next;
    logic        side_reg, side_next;     // 0 left wheel, 1 right wheel
    logic        rd_vld_reg;
    logic        m_valid_reg;
    logic        s_acc, conv_acc;
    logic        issue, hit, last, direct;
    logic        div_start, div_done, out_load;
    tmem_ctl_t   mem_ctl;

    // datapath
    logic [LEN_W-1:0]         len_cur, len_reg;
    logic [LEN_W-1:0]         issue_idx_reg, chk_idx_reg;
    logic signed [DATA_W:0]   ql_next, ql_reg, qr_reg, q_cur;
    logic [WORD_W-1:0]        rd_data;
    logic signed [DATA_W-1:0] rd_x, rd_y;
    logic signed [DATA_W-1:0] prev_x_reg, prev_y_reg;
    logic signed [DATA_W+1:0] dq_full;
    logic signed [DATA_W:0]   dx_full, dy_full;
    logic [DATA_W-1:0]        dq_reg, dx_reg;
    logic signed [DATA_W:0]   dy_reg;
    logic signed [DATA_W-1:0] y0_reg, yl_reg, yr_reg;
    logic                     y_wr;
    logic signed [DATA_W-1:0] y_val;
    logic signed [DATA_W:0]   quo_s, y_sum;
    logic [DATA_W-1:0]        div_quo;
    logic signed [DATA_W:0]   s_conv;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p, prod_reg, prod_abs;
    logic                     neg_reg;
    logic [MAG_W-1:0]         mag_reg, rnd;
    logic signed [OUT_W-1:0]  deg_val;
    logic signed [OUT_W-1:0]  outl_reg, outr_reg;
    logic                     empty_reg;
    logic signed [OUT_W-1:0]  m_left_reg, m_right_reg;
    logic                     m_empty_reg;

    assign cfg_ready = 1'b1;
    assign s_acc     = s_valid && s_ready;
    assign conv_acc  = s_acc && (s_func == FUNC_CONV);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_length_reg <= '0;
            home_left_reg    <= HOME_RESET;
            home_right_reg   <= HOME_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_TABLE_LENGTH: table_length_reg <= cfg_data[LEN_W-1:0];
                REG_HOME_LEFT:    home_left_reg    <= cfg_data;
                REG_HOME_RIGHT:   home_right_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamp the length to the table depth
    assign len_cur = (int'(table_length_reg) > TABLE_DEPTH) ? LEN_W'(TABLE_DEPTH)
                                                              : table_length_reg;
    assign ql_next = -$signed({s_left_wheel[DATA_W-1], s_left_wheel});

    // table memory; loads write only while idle, so reads never overlap a write
    assign mem_ctl.wr_en = s_acc && (s_func == FUNC_LOAD)
                           && (int'(s_point_index) < TABLE_DEPTH);
    assign mem_ctl.rd_en = issue;

    ssai_tmem #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_tmem (
        .aclk  (aclk),
        .ctl   (mem_ctl),
        .waddr (AW'(s_point_index)),
        .wdata ({s_point_in, s_point_out}),
        .raddr (AW'(issue_idx_reg)),
        .rdata (rd_data)
    );

    ssai_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (prod_abs[MAG_W-1:0]),
        .den     (dx_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    // scan compare
    assign rd_x   = rd_data[WORD_W-1:DATA_W];
    assign rd_y   = rd_data[DATA_W-1:0];
    assign q_cur  = side_reg ? qr_reg : ql_reg;
    assign hit    = rd_vld_reg && ($signed({rd_x[DATA_W-1], rd_x}) >= q_cur);
    assign last   = rd_vld_reg && !hit && (chk_idx_reg == len_reg - LEN_W'(1));
    assign direct = (chk_idx_reg == '0) || (rd_x == prev_x_reg);

    assign dq_full = $signed({q_cur[DATA_W], q_cur})
                     - $signed({{2{prev_x_reg[DATA_W-1]}}, prev_x_reg});
    assign dx_full = $signed({rd_x[DATA_W-1], rd_x})
                     - $signed({prev_x_reg[DATA_W-1], prev_x_reg});
    assign dy_full = $signed({rd_y[DATA_W-1], rd_y})
                     - $signed({prev_y_reg[DATA_W-1], prev_y_reg});

    // shared multiplier: interpolation product, then radians to degrees
    assign s_conv = side_reg
        ? ($signed({home_right_reg[DATA_W-1], home_right_reg})
           - $signed({yr_reg[DATA_W-1], yr_reg}))
        : ($signed({home_left_reg[DATA_W-1], home_left_reg})
           + $signed({yl_reg[DATA_W-1], yl_reg}));

    always_comb begin
        if (state_reg == ST_CMUL) begin
            mul_a = MUL_W'(s_conv);
            mul_b = DEG_PER_RAD_Q16;
        end else begin
            mul_a = $signed({2'b00, dq_reg});
            mul_b = MUL_W'(dy_reg);
        end
    end

    assign mul_p    = mul_a * mul_b;
    assign prod_abs = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;

    // truncate toward zero: divide magnitudes, restore the sign
    assign quo_s = neg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    assign y_sum = $signed({y0_reg[DATA_W-1], y0_reg}) + quo_s;

    always_comb begin
        y_wr  = 1'b0;
        y_val = rd_y;
        if (state_reg == ST_SCAN && hit && direct) begin
            y_wr  = 1'b1;
            y_val = (chk_idx_reg == '0) ? rd_y : prev_y_reg;
        end else if (state_reg == ST_SCAN && last) begin
            y_wr  = 1'b1;
            y_val = rd_y;
        end else if (state_reg == ST_SUM) begin
            y_wr  = 1'b1;
            y_val = y_sum[DATA_W-1:0];
        end
    end

    // round half away from zero, then saturate
    assign rnd = (mag_reg + RND_HALF) >> SH;

    always_comb begin
        if (neg_reg) begin
            deg_val = (rnd > NEG_LIM) ? OUT_MIN : -$signed(rnd[OUT_W-1:0]);
        end else begin
            deg_val = (rnd > POS_LIM) ? OUT_MAX : $signed(rnd[OUT_W-1:0]);
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        side_next  = side_reg;
        case (state_reg)
            ST_IDLE: begin
                if (conv_acc) begin
                    side_next  = 1'b0;
                    state_next = (len_cur == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    state_next = direct ? ST_NEXT : ST_MUL;
                end else if (last) begin
                    state_next = ST_NEXT;
                end
            end
            ST_MUL:  state_next = ST_DIVS;
            ST_DIVS: state_next = ST_DIVW;
            ST_DIVW: begin
                if (div_done) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:  state_next = ST_NEXT;
            ST_NEXT: begin
                side_next  = ~side_reg;
                state_next = side_reg ? ST_CMUL : ST_SCAN;
            end
            ST_CMUL: state_next = ST_CABS;
            ST_CABS: state_next = ST_CSAT;
            ST_CSAT: begin
                side_next  = ~side_reg;
                state_next = side_reg ? ST_DONE : ST_CMUL;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        issue     = (state_reg == ST_SCAN) && !hit && (issue_idx_reg < len_reg);
        div_start = (state_reg == ST_DIVS);
        out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            side_reg    <= 1'b0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            side_reg   <= side_next;
            rd_vld_reg <= issue;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (conv_acc) begin
            len_reg       <= len_cur;
            ql_reg        <= ql_next;
            qr_reg        <= $signed({s_right_wheel[DATA_W-1], s_right_wheel});
            issue_idx_reg <= '0;
            outl_reg      <= '0;
            outr_reg      <= '0;
            empty_reg     <= (len_cur == '0);
        end
        if (state_reg == ST_NEXT) begin
            issue_idx_reg <= '0;
        end
        if (issue) begin
            issue_idx_reg <= issue_idx_reg + LEN_W'(1);
            chk_idx_reg   <= issue_idx_reg;
        end
        // remember the point just passed for the interval below the hit
        if (rd_vld_reg && !hit) begin
            prev_x_reg <= rd_x;
            prev_y_reg <= rd_y;
        end
        if (state_reg == ST_SCAN && hit) begin
            dq_reg <= dq_full[DATA_W-1:0];
            dx_reg <= dx_full[DATA_W-1:0];
            dy_reg <= dy_full;
            y0_reg <= prev_y_reg;
        end
        if (y_wr) begin
            if (side_reg) begin
                yr_reg <= y_val;
            end else begin
                yl_reg <= y_val;
            end
        end
        if (state_reg == ST_MUL || state_reg == ST_CMUL) begin
            prod_reg <= mul_p;
        end
        if (state_reg == ST_DIVS) begin
            neg_reg <= prod_reg[PROD_W-1];
        end
        if (state_reg == ST_CABS) begin
            neg_reg <= prod_reg[PROD_W-1];
            mag_reg <= prod_abs[MAG_W-1:0];
        end
        if (state_reg == ST_CSAT) begin
            if (side_reg) begin
                outr_reg <= deg_val;
            end else begin
                outl_reg <= deg_val;
            end
        end
        if (out_load) begin
            m_left_reg  <= outl_reg;
            m_right_reg <= outr_reg;
            m_empty_reg <= empty_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_left_servo_deg  = m_left_reg;
    assign m_right_servo_deg = m_right_reg;
    assign m_empty_table     = m_empty_reg;

endmodule

@@ sv/ssai_checker.sv @@
// Port-level checks of the steering servo angle interpolator, bound to the top level.
`include "steering_servo_angle_interpolator_assert.svh"

module ssai_checker import ssai_pkg::*; (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     cfg_valid,
    input logic                     cfg_ready,
    input logic [CFG_IDX_W-1:0]     cfg_index,
    input logic [DATA_W-1:0]        cfg_data,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic                     s_func,
    input logic [IDX_W-1:0]         s_point_index,
    input logic signed [DATA_W-1:0] s_point_in,
    input logic signed [DATA_W-1:0] s_point_out,
    input logic signed [DATA_W-1:0] s_left_wheel,
    input logic signed [DATA_W-1:0] s_right_wheel,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic signed [OUT_W-1:0]  m_left_servo_deg,
    input logic signed [OUT_W-1:0]  m_right_servo_deg,
    input logic                     m_empty_table
);

    // a stalled result holds
    `SSAI_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_left_servo_deg) && $stable(m_right_servo_deg) && $stable(m_empty_table), "result changed while stalled")

    // an empty table gives zero angles
    `SSAI_ASSERT_SAME(a_empty_zero, m_valid && m_empty_table, m_left_servo_deg == '0 && m_right_servo_deg == '0, "empty table with nonzero angle")

    // a convert item occupies the block
    `SSAI_ASSERT_NEXT(a_conv_busy, s_valid && s_ready && s_func == FUNC_CONV, !s_ready, "ready stayed high after convert item")

    // a load item finishes in its own cycle
    `SSAI_ASSERT_NEXT(a_load_free, s_valid && s_ready && s_func == FUNC_LOAD, s_ready, "ready dropped after load item")

endmodule

bind steering_servo_angle_interpolator ssai_checker u_ssai_checker (.*);

@@ sim/ssai_angle_checker.sv @@
// Watches the servo interpolator channels, predicts each convert item and compares its result.
`timescale 1ns / 1ps
module ssai_angle_checker import ssai_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic                     s_func,
    input  logic [IDX_W-1:0]         s_point_index,
    input  logic signed [DATA_W-1:0] s_point_in,
    input  logic signed [DATA_W-1:0] s_point_out,
    input  logic signed [DATA_W-1:0] s_left_wheel,
    input  logic signed [DATA_W-1:0] s_right_wheel,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic signed [OUT_W-1:0]  m_left_servo_deg,
    input  logic signed [OUT_W-1:0]  m_right_servo_deg,
    input  logic                     m_empty_table,
    output int unsigned              mismatches,
    output int unsigned              outstanding
);

    typedef struct packed {
        logic signed [OUT_W-1:0] left_deg;
        logic signed [OUT_W-1:0] right_deg;
        logic                    empty;
    } servo_angles_t;

    servo_angles_t            pending_angles[$];
    logic signed [DATA_W-1:0] pt_x [SSAI_TABLE_DEPTH];
    logic signed [DATA_W-1:0] pt_y [SSAI_TABLE_DEPTH];
    logic [LEN_W-1:0]         table_len;
    logic signed [DATA_W-1:0] home_l;
    logic signed [DATA_W-1:0] home_r;

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(string field, longint got, longint want);
        $display("ssai_angle_checker: %s got %0d expected %0d", field, got, want);
        mismatches++;
    endtask

    // First point whose x is not below q; clamp at the ends, else interpolate.
    function automatic longint interp_offset(longint q, int n);
        int     i;
        longint x0, y0, x1, y1;
        i = 0;
        while (i < n && longint'(pt_x[i]) < q)
            i++;
        if (i == n)
            return longint'(pt_y[n-1]);
        if (i == 0)
            return longint'(pt_y[0]);
        x0 = pt_x[i-1];
        y0 = pt_y[i-1];
        x1 = pt_x[i];
        y1 = pt_y[i];
        if (x1 == x0)
            return y0;
        return y0 + ((q - x0) * (y1 - y0)) / (x1 - x0);
    endfunction

    // Radians in Q12 to 1/256 degree: round half away from zero, then saturate.
    function automatic logic signed [OUT_W-1:0] rad_to_deg256(longint s);
        longint prod, mag, deg;
        prod = s * longint'(DEG_PER_RAD_Q16);
        mag  = (prod < 0) ? -prod : prod;
        mag  = (mag + (longint'(1) << (SSAI_FRAC_BITS + 7))) >> (SSAI_FRAC_BITS + 8);
        deg  = (prod < 0) ? -mag : mag;
        if (deg > longint'(OUT_MAX))
            deg = longint'(OUT_MAX);
        if (deg < longint'(OUT_MIN))
            deg = longint'(OUT_MIN);
        return deg[OUT_W-1:0];
    endfunction

    function automatic servo_angles_t predict_angles(logic signed [DATA_W-1:0] lw,
                                                     logic signed [DATA_W-1:0] rw);
        servo_angles_t a;
        int            n;
        n = (table_len > SSAI_TABLE_DEPTH) ? SSAI_TABLE_DEPTH : int'(table_len);
        if (n == 0) begin
            a.left_deg  = '0;
            a.right_deg = '0;
            a.empty     = 1'b1;
            return a;
        end
        // left wheel is looked up negated; right result is taken from its home
        a.left_deg  = rad_to_deg256(longint'(home_l) + interp_offset(-longint'(lw), n));
        a.right_deg = rad_to_deg256(longint'(home_r) - interp_offset(longint'(rw), n));
        a.empty     = 1'b0;
        return a;
    endfunction

    always @(posedge aclk) begin : watch
        servo_angles_t want;
        if (!aresetn) begin
            table_len = '0;
            home_l    = HOME_RESET;
            home_r    = HOME_RESET;
            pending_angles.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_angles.size() == 0) begin
                    report_mismatch("result with no item pending", m_left_servo_deg, 0);
                end else begin
                    want = pending_angles.pop_front();
                    if (m_left_servo_deg !== want.left_deg)
                        report_mismatch("left_servo_deg", m_left_servo_deg, want.left_deg);
                    if (m_right_servo_deg !== want.right_deg)
                        report_mismatch("right_servo_deg", m_right_servo_deg, want.right_deg);
                    if (m_empty_table !== want.empty)
                        report_mismatch("empty_table", m_empty_table, want.empty);
                end
            end
            if (s_valid && s_ready) begin
                if (s_func == FUNC_LOAD) begin
                    pt_x[s_point_index] = s_point_in;
                    pt_y[s_point_index] = s_point_out;
                end else begin
                    pending_angles.push_back(predict_angles(s_left_wheel, s_right_wheel));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_TABLE_LENGTH: table_len = cfg_data[LEN_W-1:0];
                    REG_HOME_LEFT:    home_l    = cfg_data;
                    REG_HOME_RIGHT:   home_r    = cfg_data;
                    default: ;
                endcase
            end
        end
        outstanding <= pending_angles.size();
    end

endmodule

@@ sim/tb_top.sv @@
// Stimulus, clock, reset and verdict for the steering servo angle interpolator.
`timescale 1ns / 1ps
module tb_top;
    import ssai_pkg::*;

    localparam int     WATCHDOG_LIMIT = 5000;
    localparam int     SETTLE_CYCLES  = 2 * SSAI_TABLE_DEPTH + 72;
    localparam int     RANDOM_ITEMS   = 450;
    localparam int     SQUEEZE_CYCLES = 400;
    localparam longint ANGLE_MIN      = -8388608;
    localparam longint ANGLE_MAX      = 8388607;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum {
        SHAPE_SORTED,
        SHAPE_WITH_TIES,
        SHAPE_SCRAMBLED
    } table_shape_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [DATA_W-1:0]        cfg_data;
    logic                     s_valid;
    logic                     s_ready;
    logic                     s_func;
    logic [IDX_W-1:0]         s_point_index;
    logic signed [DATA_W-1:0] s_point_in;
    logic signed [DATA_W-1:0] s_point_out;
    logic signed [DATA_W-1:0] s_left_wheel;
    logic signed [DATA_W-1:0] s_right_wheel;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [OUT_W-1:0]  m_left_servo_deg;
    logic signed [OUT_W-1:0]  m_right_servo_deg;
    logic                     m_empty_table;
    int unsigned              mismatches;
    int unsigned              outstanding;

    bit          steady_flow;
    bit          squeeze_req;
    int unsigned items_sent;
    int          table_span;
    longint      slot_x [SSAI_TABLE_DEPTH];

    steering_servo_angle_interpolator dut (.*);
    ssai_angle_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic longint rand_angle();
        logic [31:0]              r;
        logic signed [DATA_W-1:0] v;
        r = $urandom();
        v = r[DATA_W-1:0];
        return v;
    endfunction

    function automatic longint clip_angle(longint v);
        if (v > ANGLE_MAX)
            return ANGLE_MAX;
        if (v < ANGLE_MIN)
            return ANGLE_MIN;
        return v;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 90);
    endfunction

    function automatic longint pick_home();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return ANGLE_MAX;
        if (r < 4)
            return ANGLE_MIN;
        if (r == 4)
            return HOME_RESET;
        return rand_angle();
    endfunction

    // Mostly aim near a loaded point so the search lands between neighbors.
    function automatic longint pick_query();
        int unsigned r;
        int          k;
        r = $urandom_range(0, 99);
        if (r < 7)
            return ANGLE_MIN;
        if (r < 14)
            return ANGLE_MAX;
        if (r < 35 || table_span == 0)
            return rand_angle();
        k = $urandom_range(0, table_span - 1);
        return clip_angle(slot_x[k] + longint'($urandom_range(0, 200)) - 100);
    endfunction

    task automatic send_item(func_t fn, logic [IDX_W-1:0] idx, longint px, longint py,
                             longint lw, longint rw);
        int unsigned gap;
        gap = steady_flow ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_func        <= fn;
        s_point_index <= idx;
        s_point_in    <= px[DATA_W-1:0];
        s_point_out   <= py[DATA_W-1:0];
        s_left_wheel  <= lw[DATA_W-1:0];
        s_right_wheel <= rw[DATA_W-1:0];
        if (fn == FUNC_LOAD)
            slot_x[idx] = px;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_convert();
        longint q, lw;
        q = pick_query();
        if ($urandom_range(0, 19) == 0)
            lw = ANGLE_MIN;
        else
            lw = (q == ANGLE_MIN) ? ANGLE_MAX : -q;
        send_item(FUNC_CONV, $urandom_range(0, 63), rand_angle(), rand_angle(), lw, pick_query());
    endtask

    task automatic load_table(int n, table_shape_t shape);
        longint x, stride;
        x      = ANGLE_MIN + longint'($urandom_range(0, 4194304));
        stride = (ANGLE_MAX - x) / n;
        if ($urandom_range(0, 2) == 0)
            stride = $urandom_range(1, 64);
        for (int k = 0; k < n; k++) begin
            if (shape == SHAPE_SCRAMBLED)
                x = rand_angle();
            else if (k > 0 && !(shape == SHAPE_WITH_TIES && $urandom_range(0, 3) == 0))
                x = clip_angle(x + longint'($urandom_range(1, stride)));
            send_item(FUNC_LOAD, k, x, rand_angle(), rand_angle(), rand_angle());
        end
    endtask

    // Hold the register write until the last convert item has drained.
    task automatic drain_and_settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    initial begin : receiver
        int unsigned hold;
        bit          open;
        hold    = 0;
        open    = 1'b0;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                open        = 1'b0;
                hold        = SQUEEZE_CYCLES;
            end else if (hold == 0) begin
                if (open) begin
                    open = 1'b0;
                    hold = pick_gap() + 1;
                end else begin
                    open = 1'b1;
                    hold = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 300)
                                                       : $urandom_range(1, 12);
                end
            end
            hold--;
            m_ready <= open;
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        wait (aresetn === 1'b1);
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin : stimulus
        int               phase;
        int unsigned      directed_items;
        int unsigned      convert_count;
        int unsigned      roll;
        logic [LEN_W-1:0] len;
        logic [31:0]      pad;
        longint           hl, hr;
        table_shape_t     shape;

        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_func        = FUNC_LOAD;
        s_point_index = '0;
        s_point_in    = '0;
        s_point_out   = '0;
        s_left_wheel  = '0;
        s_right_wheel = '0;
        steady_flow   = 1'b0;
        squeeze_req   = 1'b0;
        items_sent    = 0;
        table_span    = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table straight out of reset
        send_item(FUNC_CONV, 0, 0, 0, ANGLE_MIN, ANGLE_MAX);
        send_item(FUNC_CONV, 63, ANGLE_MAX, ANGLE_MIN, 0, 0);
        // four points spanning the whole range, falling then rising then falling
        send_item(FUNC_LOAD, 0, ANGLE_MIN, ANGLE_MAX, rand_angle(), rand_angle());
        send_item(FUNC_LOAD, 1, -4096, -1000, rand_angle(), rand_angle());
        send_item(FUNC_LOAD, 2, 4096, 5000, rand_angle(), rand_angle());
        send_item(FUNC_LOAD, 3, ANGLE_MAX, ANGLE_MIN, rand_angle(), rand_angle());
        drain_and_settle();
        write_reg(REG_TABLE_LENGTH, 4);
        cfg_valid  <= 1'b0;
        table_span = 4;
        // past the top end, at the bottom point, between points, on a point
        send_item(FUNC_CONV, 0, 0, 0, ANGLE_MIN, ANGLE_MIN);
        send_item(FUNC_CONV, 0, 0, 0, ANGLE_MAX, ANGLE_MAX);
        send_item(FUNC_CONV, 0, 0, 0, 0, 0);
        send_item(FUNC_CONV, 0, 0, 0, 4096, -5000);
        // repeated x value next to slot 1
        send_item(FUNC_LOAD, 2, -4096, 777, rand_angle(), rand_angle());
        send_item(FUNC_CONV, 0, 0, 0, 4096, -4095);
        send_item(FUNC_CONV, 0, 0, 0, 4095, -4096);
        directed_items = items_sent;

        phase = 0;
        while (items_sent < directed_items + RANDOM_ITEMS) begin
            drain_and_settle();
            hl = pick_home();
            hr = pick_home();
            case (phase)
                0: begin
                    len = 1;
                    hl  = ANGLE_MAX;
                    hr  = ANGLE_MIN;
                end
                1: begin
                    len = 127;
                    hl  = ANGLE_MIN;
                    hr  = ANGLE_MAX;
                end
                2: len = 4;
                3: len = 0;
                4: len = 64;
                default: begin
                    roll = $urandom_range(0, 99);
                    if (roll < 70)
                        len = $urandom_range(2, 8);
                    else if (roll < 85)
                        len = $urandom_range(0, 1);
                    else if (roll < 95)
                        len = $urandom_range(9, 24);
                    else
                        len = $urandom_range(65, 127);
                end
            endcase
            pad = $urandom();
            write_reg(REG_TABLE_LENGTH, {pad[DATA_W-1:LEN_W], len});
            write_reg(REG_HOME_LEFT, hl[DATA_W-1:0]);
            write_reg(REG_HOME_RIGHT, hr[DATA_W-1:0]);
            if (phase == 3)
                write_reg(REG_SPARE, pad[DATA_W-1:0]);
            cfg_valid  <= 1'b0;
            table_span = (len > SSAI_TABLE_DEPTH) ? SSAI_TABLE_DEPTH : len;

            roll = $urandom_range(0, 99);
            shape = (roll < 70) ? SHAPE_SORTED : (roll < 85) ? SHAPE_WITH_TIES
                                                             : SHAPE_SCRAMBLED;
            if (table_span > 0)
                load_table(table_span, shape);

            // phase 2 backs up the result channel while items keep coming
            steady_flow = (phase == 2) || (phase % 4 == 3);
            if (phase == 2)
                squeeze_req = 1'b1;
            convert_count = (phase == 2) ? 16 : $urandom_range(6, 24);
            repeat (convert_count) begin
                if (phase != 2 && $urandom_range(0, 9) == 0)
                    send_item(FUNC_LOAD, $urandom_range(0, 63), rand_angle(), rand_angle(),
                              rand_angle(), rand_angle());
                else
                    send_convert();
            end
            steady_flow = 1'b0;
            phase++;
        end

        drain_and_settle();
        if (mismatches == 0 && outstanding == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
